### src/lfsd_pkg.sv
package lfsd_pkg;

  // start bytes, end marker and minimum length of a frame
  localparam logic [7:0] START_RX = 8'hC0;
  localparam logic [7:0] START_TX = 8'h0C;
  localparam logic [7:0] END_MARK = 8'hAA;
  localparam logic [7:0] MIN_LEN  = 8'd3;

  // frame_status codes
  localparam logic [1:0] STATUS_INSIDE    = 2'd0;
  localparam logic [1:0] STATUS_START_ERR = 2'd1;
  localparam logic [1:0] STATUS_GOOD      = 2'd2;
  localparam logic [1:0] STATUS_BAD       = 2'd3;

  typedef struct packed {
    logic       port_id;
    logic [7:0] data_byte;
  } byte_beat_t;

  typedef struct packed {
    logic       out_port;
    logic [7:0] out_byte;
    logic [7:0] frame_position;
    logic       direction;
    logic [1:0] frame_status;
    logic       frame_end;
  } echo_beat_t;

  // per-port frame tracker, byte_count of zero means no frame open
  typedef struct packed {
    logic [7:0] byte_count;
    logic [7:0] frame_length;
    logic       frame_direction;
  } port_state_t;

endpackage

### src/lfsd_frame_step.sv
module lfsd_frame_step
  import lfsd_pkg::*;
(
  input  byte_beat_t  beat,
  input  logic        port_ok,
  input  port_state_t cur,
  output port_state_t nxt,
  output echo_beat_t  echo
);

  logic [8:0] count_inc;

  assign count_inc = {1'b0, cur.byte_count} + 9'd1;

  always_comb begin
    nxt                 = cur;
    echo.out_port       = beat.port_id;
    echo.out_byte       = beat.data_byte;
    echo.frame_position = 8'd0;
    echo.direction      = 1'b0;
    echo.frame_status   = STATUS_START_ERR;
    echo.frame_end      = 1'b0;
    if (port_ok) begin
      if (cur.byte_count == 8'd0) begin
        // hunting for a start byte
        if (beat.data_byte == START_RX || beat.data_byte == START_TX) begin
          nxt.frame_direction = (beat.data_byte == START_TX);
          nxt.byte_count      = 8'd1;
          echo.direction      = (beat.data_byte == START_TX);
          echo.frame_status   = STATUS_INSIDE;
        end
      end else if (cur.byte_count == 8'd1) begin
        // length byte
        echo.frame_position = 8'd1;
        echo.direction      = cur.frame_direction;
        nxt.frame_length    = beat.data_byte;
        if (beat.data_byte < MIN_LEN) begin
          echo.frame_status = STATUS_BAD;
          echo.frame_end    = 1'b1;
          nxt.byte_count    = 8'd0;
        end else begin
          echo.frame_status = STATUS_INSIDE;
          nxt.byte_count    = 8'd2;
        end
      end else begin
        echo.frame_position = cur.byte_count;
        echo.direction      = cur.frame_direction;
        if (count_inc >= {1'b0, cur.frame_length}) begin
          echo.frame_status = (beat.data_byte == END_MARK) ? STATUS_GOOD : STATUS_BAD;
          echo.frame_end    = 1'b1;
          nxt.byte_count    = 8'd0;
        end else begin
          echo.frame_status = STATUS_INSIDE;
          nxt.byte_count    = count_inc[7:0];
        end
      end
    end
  end

endmodule

### src/length_framed_serial_deframer.sv
// Byte-stream frame deframer for up to NUM_PORTS serial ports. Each byte
// beat carries a port number and a raw byte; every accepted beat yields
// exactly one echo beat with the byte, its place in the frame, the frame
// direction (0xC0 start = receive, 0x0C start = transmit), a status code
// and an end-of-frame flag. Frames are start byte, length byte (total
// length, start byte included), payload, and an 0xAA end marker on the
// last byte; lengths below 3 close the frame as bad on the length byte.
// Bytes outside a frame that are not start bytes, and bytes on a port
// number of NUM_PORTS or more, come back as start errors and leave all
// trackers alone. Throughput is one byte per clock on any mix of ports
// while the echo side is ready: the per-port tracker is read and written
// in the same cycle by the step logic between the input register and the
// echo register. Each byte passes the input register, then the echo
// register, before its echo beat goes valid. Both sides use valid/ready;
// the input register, when empty, takes a new byte while a finished echo still waits.
module length_framed_serial_deframer
  import lfsd_pkg::*;
#(
  parameter int NUM_PORTS = 2
) (
  input  logic       clk,
  input  logic       rst,
  // byte beats in
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_beat_t byte_beat,
  // echo beats out
  output logic       echo_valid,
  input  logic       echo_ready,
  output echo_beat_t echo_beat
);

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // input register stage
  logic        s1_valid;
  byte_beat_t  s1_beat;
  logic        s1_adv;

  // per-port frame trackers
  port_state_t trackers [NUM_PORTS];

  logic        port_ok;
  logic [IDX_W-1:0] port_idx;
  port_state_t cur_state;
  port_state_t nxt_state;
  echo_beat_t  step_echo;

  // stage 1 moves on when the echo register is empty or being drained
  assign s1_adv     = s1_valid && (!echo_valid || echo_ready);
  assign byte_ready = !s1_valid || !echo_valid || echo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_beat <= byte_beat;
    end
  end

  // port numbers beyond the tracker count are start errors
  assign port_ok  = ({31'd0, s1_beat.port_id} < 32'(NUM_PORTS));
  assign port_idx = port_ok ? IDX_W'(s1_beat.port_id) : '0;

  assign cur_state = trackers[port_idx];

  lfsd_frame_step u_step (
    .beat    (s1_beat),
    .port_ok (port_ok),
    .cur     (cur_state),
    .nxt     (nxt_state),
    .echo    (step_echo)
  );

  // tracker write-back, same cycle as the read so back-to-back bytes on
  // one port see the updated count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        trackers[p] <= '0;
      end
    end else if (s1_adv && port_ok) begin
      trackers[port_idx] <= nxt_state;
    end
  end

  // echo register
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_valid <= 1'b0;
    end else if (!echo_valid || echo_ready) begin
      echo_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      echo_beat <= step_echo;
    end
  end

  // a frame end is always good or bad, and good only on a frame end
  a_end_status: assert property (@(posedge clk) disable iff (rst)
    echo_valid |-> (echo_beat.frame_end ==
      (echo_beat.frame_status == STATUS_GOOD || echo_beat.frame_status == STATUS_BAD)))
    else $error("frame_end disagrees with frame_status");

  // dropped bytes carry no position and no direction
  a_start_err: assert property (@(posedge clk) disable iff (rst)
    (echo_valid && echo_beat.frame_status == STATUS_START_ERR) |->
      (echo_beat.frame_position == 8'd0 && !echo_beat.direction))
    else $error("start error beat with position or direction set");

  // past the length byte, port 0's count stays below its frame length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (trackers[0].byte_count > 8'd1) |-> (trackers[0].byte_count < trackers[0].frame_length))
    else $error("port 0 byte count reached frame length without closing");

  // a waiting echo is not overwritten by the step logic
  a_echo_hold: assert property (@(posedge clk) disable iff (rst)
    (echo_valid && !echo_ready) |-> !s1_adv)
    else $error("stage 1 advanced into a stalled echo register");

endmodule
